// ===== rtl/core/dstk_pkg.sv =====
// shared types and constants for the delimited record stack
// no dependencies
package dstk_pkg;

  localparam int unsigned MaxOut = 63;
  localparam int unsigned CntW   = 6;

  typedef enum logic [1:0] {
    REQ_PUSH_CHAR = 2'd0,
    REQ_PUSH_END  = 2'd1,
    REQ_POP       = 2'd2,
    REQ_TOP       = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_DATA  = 3'd0,
    ST_OK    = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FULL  = 3'd3,
    ST_OPEN  = 3'd4,
    ST_LONG  = 3'd5
  } status_e;

  typedef struct packed {
    logic    push_char;
    logic    push_end;
    logic    scan_init;
    logic    scan_rd;
    logic    scan_step;
    logic    set_start;
    logic    emit_rd;
    logic    emit_step;
    logic    drop_rec;
    logic    out_ld_single;
    logic    out_ld_data;
    logic    out_last;
    status_e out_status;
  } dstk_cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic rec_open;
    logic too_long;
    logic full_char;
    logic full_end;
    logic empty;
    logic scan_hit;
    logic rec_empty;
    logic emit_done;
  } dstk_flags_t;

endpackage

// ===== rtl/core/dstk_if.sv =====
// request and response channel interfaces of the record stack
// depends on nothing beyond the port widths fixed here
interface dstk_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface dstk_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== rtl/core/dstk_ctrl.sv =====
// control state machine of the record stack: handshakes and command sequencing
// depends on dstk_pkg
module dstk_ctrl
  import dstk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  dstk_flags_t flags_i,
  output dstk_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN_RD  = 5'b00010,
    S_SCAN_CHK = 5'b00100,
    S_EMIT_RD  = 5'b01000,
    S_EMIT_OUT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   pop_q, pop_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = ST_OK;
    state_d          = state_q;
    pop_d            = pop_q;
    in_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          case (req_type_i)
            REQ_PUSH_CHAR: begin
              cmd_o.out_ld_single = 1'b1;
              if (flags_i.byte_zero) begin
                cmd_o.out_status = ST_OK;
              end else if (flags_i.too_long) begin
                cmd_o.out_status = ST_LONG;
              end else if (flags_i.full_char) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.push_char = 1'b1;
              end
            end
            REQ_PUSH_END: begin
              cmd_o.out_ld_single = 1'b1;
              if (!flags_i.rec_open) begin
                cmd_o.out_status = ST_OK;
              end else if (flags_i.full_end) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.push_end = 1'b1;
              end
            end
            REQ_POP, REQ_TOP: begin
              if (flags_i.rec_open) begin
                cmd_o.out_ld_single = 1'b1;
                cmd_o.out_status    = ST_OPEN;
              end else if (flags_i.empty) begin
                cmd_o.out_ld_single = 1'b1;
                cmd_o.out_status    = ST_EMPTY;
              end else begin
                cmd_o.scan_init = 1'b1;
                pop_d           = (req_type_i == REQ_POP);
                state_d         = S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!flags_i.scan_hit) begin
          cmd_o.scan_step = 1'b1;
          state_d         = S_SCAN_RD;
        end else if (!flags_i.rec_empty) begin
          cmd_o.set_start = 1'b1;
          state_d         = S_EMIT_RD;
        end else if (out_free) begin
          cmd_o.out_ld_single = 1'b1;
          cmd_o.out_status    = ST_EMPTY;
          state_d             = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          cmd_o.out_ld_data = 1'b1;
          cmd_o.out_status  = ST_DATA;
          cmd_o.out_last    = flags_i.emit_done;
          if (flags_i.emit_done) begin
            cmd_o.drop_rec = pop_q;
            state_d        = S_IDLE;
          end else begin
            cmd_o.emit_step = 1'b1;
            state_d         = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld_single || cmd_o.out_ld_data) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pop_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pop_q       <= pop_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/dstk_dp.sv =====
// datapath of the record stack: byte store, fill and scan pointers, result register
// depends on dstk_pkg
module dstk_dp
  import dstk_pkg::*;
#(
  parameter int unsigned DEPTH   = 1024,
  parameter int unsigned MAX_LEN = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  dstk_cmd_t   cmd_i,
  output dstk_flags_t flags_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [7:0]    mem [DEPTH];
  logic [FW-1:0] fill_q, fill_d;
  logic          open_q, open_d;
  logic [LW-1:0] olen_q, olen_d;
  logic [AW-1:0] ptr_q, end_q, start_q;
  logic [AW:0]   ptr_inc;
  logic [CntW-1:0] cnt_q;
  logic [7:0]    rd_data_q;
  logic [7:0]    out_byte_q;
  status_e       out_status_q;
  logic          out_last_q;
  logic          wr_en;
  logic [7:0]    wr_data;

  assign ptr_inc = {1'b0, ptr_q} + 1'b1;

  assign flags_o.byte_zero = (data_byte_i == 8'd0);
  assign flags_o.rec_open  = open_q;
  assign flags_o.too_long  = (olen_q >= LW'(MAX_LEN));
  assign flags_o.full_char = (fill_q >= FW'(DEPTH - 1));
  assign flags_o.full_end  = (fill_q >= FW'(DEPTH));
  assign flags_o.empty     = (fill_q <= FW'(1));
  assign flags_o.scan_hit  = (ptr_q == '0) || (rd_data_q == 8'd0);
  assign flags_o.rec_empty = (ptr_inc == {1'b0, end_q});
  assign flags_o.emit_done = (ptr_inc == {1'b0, end_q}) || (cnt_q == CntW'(MaxOut - 1));

  assign wr_en   = cmd_i.push_char || cmd_i.push_end;
  assign wr_data = cmd_i.push_char ? data_byte_i : 8'd0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[AW-1:0]] <= wr_data;
    end
    if (cmd_i.scan_rd || cmd_i.emit_rd) begin
      rd_data_q <= mem[ptr_q];
    end
  end

  always_comb begin
    fill_d = fill_q;
    open_d = open_q;
    olen_d = olen_q;
    if (cmd_i.push_char) begin
      fill_d = fill_q + 1'b1;
      open_d = 1'b1;
      olen_d = olen_q + 1'b1;
    end else if (cmd_i.push_end) begin
      fill_d = fill_q + 1'b1;
      open_d = 1'b0;
      olen_d = '0;
    end else if (cmd_i.drop_rec) begin
      fill_d = FW'(start_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= FW'(1);
      open_q <= 1'b0;
      olen_q <= '0;
    end else begin
      fill_q <= fill_d;
      open_q <= open_d;
      olen_q <= olen_d;
    end
  end

  // scan and emit pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      ptr_q <= AW'(fill_q - FW'(2));
      end_q <= AW'(fill_q - FW'(1));
    end else if (cmd_i.scan_step) begin
      ptr_q <= ptr_q - 1'b1;
    end else if (cmd_i.set_start) begin
      ptr_q   <= ptr_inc[AW-1:0];
      start_q <= ptr_inc[AW-1:0];
      cnt_q   <= '0;
    end else if (cmd_i.emit_step) begin
      ptr_q <= ptr_inc[AW-1:0];
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld_single) begin
      out_byte_q   <= 8'd0;
      out_status_q <= cmd_i.out_status;
      out_last_q   <= 1'b1;
    end else if (cmd_i.out_ld_data) begin
      out_byte_q   <= rd_data_q;
      out_status_q <= ST_DATA;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign out_byte_o = out_byte_q;
  assign status_o   = out_status_q;
  assign last_o     = out_last_q;

endmodule

// ===== rtl/core/delimited_record_stack_core.sv =====
// top level of the delimited record stack: controller plus datapath
// depends on dstk_pkg, dstk_if, dstk_ctrl, dstk_dp
//
// Stack of variable-length byte records held in one DEPTH-entry byte store,
// each record closed by a zero terminator. push_char and push_end each
// answer with one transfer, so pushes stream at one item per cycle while
// every response is taken at once. pop and top walk back from the newest
// terminator through the single read port of the store, one entry at a
// time, the terminator before the record included, then read the record
// out one byte at a time, one transfer per byte with last on the final one.
// No requests are taken while a pop or top is in progress. The store needs
// no clearing after reset.
module delimited_record_stack_core
  import dstk_pkg::*;
#(
  parameter int unsigned DEPTH   = 1024,
  parameter int unsigned MAX_LEN = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dstk_req_if.sink   req_i,
  dstk_rsp_if.source rsp_o
);

  dstk_cmd_t   cmd;
  dstk_flags_t flags;
  logic        in_ready;
  logic        out_valid;

  dstk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_i.req_type),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  dstk_dp #(
    .DEPTH   (DEPTH),
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (req_i.data_byte),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .out_byte_o  (rsp_o.out_byte),
    .status_o    (rsp_o.status),
    .last_o      (rsp_o.last)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

// ===== test/delimited_record_stack_core_test.sv =====
// self-checking testbench for delimited_record_stack_core: directed table, then random records
// depends on dstk_pkg, dstk_if and the rtl under rtl/core
module delimited_record_stack_core_test;
  import dstk_pkg::*;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned MAX_LEN    = 63;
  localparam int unsigned StuckLimit = 5000;
  localparam int unsigned SettleCyc  = 300;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } rsp_t;

  typedef struct packed {
    req_e        op;
    logic [7:0]  data;
    int unsigned reps;
    logic        lit;
    status_e     want;
  } step_t;

  logic clk_i;
  logic rst_ni;

  dstk_req_if req_bus ();
  dstk_rsp_if rsp_bus ();

  delimited_record_stack_core #(
    .DEPTH  (DEPTH),
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // shadow copy of the stack
  logic [7:0]  shadow_mem [DEPTH];
  int unsigned shadow_fill;
  logic        shadow_open;
  int unsigned shadow_len;

  rsp_t        owed_rsp [$];
  int unsigned mismatch_count;
  int unsigned req_count;
  int unsigned rsp_count;
  int unsigned full_count;
  int unsigned long_count;
  int unsigned stuck_cycles;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned stall_left;

  logic    lit_on;
  status_e lit_status;

  step_t plan [0:20] = '{
    '{REQ_POP,       8'h00,  1, 1'b1, ST_EMPTY},  // empty after reset
    '{REQ_TOP,       8'h00,  1, 1'b1, ST_EMPTY},
    '{REQ_PUSH_END,  8'h00,  1, 1'b1, ST_OK},     // close with nothing open
    '{REQ_PUSH_CHAR, 8'h00,  1, 1'b1, ST_OK},     // zero byte dropped
    '{REQ_PUSH_CHAR, 8'hff,  1, 1'b1, ST_OK},
    '{REQ_TOP,       8'h5a,  1, 1'b1, ST_OPEN},   // read while open
    '{REQ_POP,       8'ha5,  1, 1'b1, ST_OPEN},
    '{REQ_PUSH_CHAR, 8'h01,  1, 1'b1, ST_OK},
    '{REQ_PUSH_END,  8'hff,  1, 1'b1, ST_OK},
    '{REQ_TOP,       8'h00,  1, 1'b0, ST_DATA},
    '{REQ_PUSH_CHAR, 8'h80,  1, 1'b1, ST_OK},
    '{REQ_PUSH_END,  8'h00,  1, 1'b1, ST_OK},
    '{REQ_POP,       8'h00,  1, 1'b0, ST_DATA},
    '{REQ_POP,       8'h00,  1, 1'b0, ST_DATA},
    '{REQ_POP,       8'h00,  1, 1'b1, ST_EMPTY},
    '{REQ_PUSH_CHAR, 8'h7f, 63, 1'b1, ST_OK},     // longest record
    '{REQ_PUSH_CHAR, 8'hc3,  1, 1'b1, ST_LONG},   // one byte too many
    '{REQ_PUSH_END,  8'h00,  1, 1'b1, ST_OK},
    '{REQ_TOP,       8'h00,  1, 1'b0, ST_DATA},
    '{REQ_POP,       8'h00,  1, 1'b0, ST_DATA},
    '{REQ_TOP,       8'h00,  1, 1'b1, ST_EMPTY}
  };

  function automatic void owe(input logic [7:0] data, input status_e status,
                              input logic last);
    owed_rsp.push_back('{data, status, last});
  endfunction

  function automatic void stack_step(input req_e op, input logic [7:0] data);
    int unsigned term_idx;
    int unsigned scan;
    int unsigned first;
    int unsigned n;
    case (op)
      REQ_PUSH_CHAR: begin
        if (data == 8'h00) begin
          owe(8'h00, ST_OK, 1'b1);
        end else if (shadow_len >= MAX_LEN) begin
          owe(8'h00, ST_LONG, 1'b1);
        end else if (shadow_fill + 1 >= DEPTH) begin
          owe(8'h00, ST_FULL, 1'b1);
        end else begin
          shadow_mem[shadow_fill] = data;
          shadow_fill++;
          shadow_len++;
          shadow_open = 1'b1;
          owe(8'h00, ST_OK, 1'b1);
        end
      end
      REQ_PUSH_END: begin
        if (!shadow_open) begin
          owe(8'h00, ST_OK, 1'b1);
        end else if (shadow_fill >= DEPTH) begin
          owe(8'h00, ST_FULL, 1'b1);
        end else begin
          shadow_mem[shadow_fill] = 8'h00;
          shadow_fill++;
          shadow_open = 1'b0;
          shadow_len  = 0;
          owe(8'h00, ST_OK, 1'b1);
        end
      end
      default: begin
        if (shadow_open) begin
          owe(8'h00, ST_OPEN, 1'b1);
        end else if (shadow_fill <= 1 || shadow_fill > DEPTH) begin
          owe(8'h00, ST_EMPTY, 1'b1);
        end else begin
          term_idx = shadow_fill - 1;
          scan     = term_idx;
          while (scan > 0) begin
            scan--;
            if (shadow_mem[scan] == 8'h00) break;
          end
          first = scan + 1;
          if (first >= term_idx) begin
            owe(8'h00, ST_EMPTY, 1'b1);
          end else begin
            n = 0;
            for (int unsigned k = first; k < term_idx && n < MaxOut; k++) begin
              owe(shadow_mem[k], ST_DATA, (k == term_idx - 1) || (n == MaxOut - 1));
              n++;
            end
            if (op == REQ_POP) shadow_fill = first;
          end
        end
      end
    endcase
  endfunction

  // transfer monitor: prediction on request, comparison on response
  always @(posedge clk_i) begin
    rsp_t want;
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        moved = 1'b1;
        req_count++;
        stack_step(req_e'(req_bus.req_type), req_bus.data_byte);
        if (lit_on) begin
          void'(owed_rsp.pop_back());
          owe(8'h00, lit_status, 1'b1);
        end
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        moved = 1'b1;
        rsp_count++;
        if (rsp_bus.status == ST_FULL) full_count++;
        if (rsp_bus.status == ST_LONG) long_count++;
        if (owed_rsp.size() == 0) begin
          $display("%0t: unexpected transfer, actual byte %h status %0d last %b", $time,
                   rsp_bus.out_byte, rsp_bus.status, rsp_bus.last);
          mismatch_count++;
        end else begin
          want = owed_rsp.pop_front();
          if (rsp_bus.out_byte !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data,
                     rsp_bus.out_byte);
            mismatch_count++;
          end
          if (rsp_bus.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     rsp_bus.status);
            mismatch_count++;
          end
          if (rsp_bus.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, rsp_bus.last);
            mismatch_count++;
          end
        end
      end
      if (moved) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d responses outstanding", $time,
                 stuck_cycles, owed_rsp.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // response side back-pressure in bursts
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (rx_gap != 0 && $urandom_range(1, 100) <= rx_gap) begin
        stall_left = $urandom_range(0, 16);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input req_e op, input logic [7:0] data, input logic lit,
                           input status_e want);
    if (tx_gap != 0 && $urandom_range(1, 100) <= tx_gap) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= op;
    req_bus.data_byte <= data;
    lit_on            <= lit;
    lit_status        <= want;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  task automatic send_rand(input req_e op);
    send_item(op, 8'($urandom_range(0, 255)), 1'b0, ST_DATA);
  endtask

  task automatic push_record(input int unsigned len);
    logic [7:0] data;
    for (int unsigned k = 0; k < len; k++) begin
      data = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_item(REQ_PUSH_CHAR, data, 1'b0, ST_DATA);
    end
  endtask

  task automatic drain_owed();
    req_bus.valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    shadow_mem[0]     = 8'h00;
    shadow_fill       = 1;
    shadow_open       = 1'b0;
    shadow_len        = 0;
    mismatch_count    = 0;
    req_count         = 0;
    rsp_count         = 0;
    full_count        = 0;
    long_count        = 0;
    stuck_cycles      = 0;
    stall_left        = 0;
    tx_gap            = 20;
    rx_gap            = 20;
    rst_ni            <= 1'b0;
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= REQ_PUSH_CHAR;
    req_bus.data_byte <= 8'h00;
    lit_on            <= 1'b0;
    lit_status        <= ST_DATA;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      for (int unsigned k = 0; k < plan[i].reps; k++) begin
        send_item(plan[i].op, plan[i].data, plan[i].lit, plan[i].want);
      end
    end

    // random records with noise in between
    repeat (10) begin
      tx_gap = ($urandom_range(0, 3) == 0) ? 0 : 25;
      rx_gap = ($urandom_range(0, 3) == 0) ? 0 : 25;
      pick   = $urandom_range(0, 9);
      if (pick < 6) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_LEN - 2, MAX_LEN + 2)
                                          : $urandom_range(1, 8);
        push_record(len);
        if ($urandom_range(0, 9) != 0) send_rand(REQ_PUSH_END);
        if ($urandom_range(0, 1) != 0) send_rand($urandom_range(0, 1) ? REQ_POP : REQ_TOP);
      end else if (pick < 9) begin
        send_rand((pick == 7) ? REQ_TOP : REQ_POP);
      end else begin
        send_rand(req_e'($urandom_range(0, 3)));
      end
    end

    // hold off until every response is in
    drain_owed();

    // closing stretch at full rate
    send_rand(REQ_PUSH_END);
    tx_gap = 0;
    rx_gap = 0;
    repeat (6) begin
      push_record($urandom_range(1, 6));
      send_rand(REQ_PUSH_END);
      send_rand($urandom_range(0, 1) ? REQ_POP : REQ_TOP);
    end
    repeat (10) send_rand(req_e'($urandom_range(0, 3)));

    drain_owed();
    repeat (SettleCyc) @(posedge clk_i);

    $display("%0d requests and %0d response transfers checked, %0d full, %0d too long",
             req_count, rsp_count, full_count, long_count);
    $display("records from one byte to past the length limit, empty and open reads, zero bytes");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dstk_pkg.sv
rtl/core/dstk_if.sv
rtl/core/dstk_ctrl.sv
rtl/core/dstk_dp.sv
rtl/core/delimited_record_stack_core.sv
test/delimited_record_stack_core_test.sv
